FILE: rtl/core/rgbds_pkg.sv
// Shared types and constants for the 2x2 RGB box-filter downscaler.
// Used by rgbds_raster_ctrl, rgb_box_downscale_2x2 and rgbds_checker.
// No dependencies.
`default_nettype none

package rgbds_pkg;

   // Line geometry.
   localparam int MAX_WIDTH   = 2048;
   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int LINE_ADDR_W = $clog2(LINE_DEPTH);
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int EFF_WIDTH_W = COL_W + 1;

   // Configuration register widths.
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 16;
   localparam int EFF_HEIGHT_W = HEIGHT_REG_W + 1;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Datapath widths.
   localparam int CHAN_W  = 8;
   localparam int PAIR_W  = CHAN_W + 1;
   localparam int TOTAL_W = CHAN_W + 2;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // One input pixel.
   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_data_type;

   // One output pixel.
   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_end;
   } rsp_data_type;

   // Horizontal pair sums, one line store entry.
   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
   } pair_sum_type;

   // Raster position of the pixel at the head of the input channel.
   typedef struct packed {
      logic                   odd_col;
      logic                   odd_row;
      logic                   last;
      logic [LINE_ADDR_W-1:0] line_addr;
   } pos_type;

endpackage

`default_nettype wire

FILE: rtl/core/rgbds_raster_ctrl.sv
// Configuration registers and raster column/row counters of the downscaler.
// Depends on rgbds_pkg.
`default_nettype none

module rgbds_raster_ctrl (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   input  wire logic [rgbds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rgbds_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                               advance,
   output rgbds_pkg::pos_type                      pos
);

   logic [rgbds_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [rgbds_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic [rgbds_pkg::COL_W-1:0]        col_ff, col_in;
   logic [rgbds_pkg::HEIGHT_REG_W-1:0] row_ff, row_in;

   logic [rgbds_pkg::EFF_WIDTH_W-1:0]  eff_width;
   logic [rgbds_pkg::EFF_WIDTH_W-1:0]  even_width;
   logic [rgbds_pkg::EFF_WIDTH_W-1:0]  col_plus;
   logic [rgbds_pkg::EFF_HEIGHT_W-1:0] eff_height;
   logic [rgbds_pkg::EFF_HEIGHT_W-1:0] even_height;
   logic [rgbds_pkg::EFF_HEIGHT_W-1:0] row_plus;

   // Configuration writes; the port is always ready.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rgbds_pkg::WIDTH_REG_W'(2);
         height_ff <= rgbds_pkg::HEIGHT_REG_W'(2);
      end else if (csr_valid) begin
         if (csr_index == rgbds_pkg::CSR_IMAGE_WIDTH) begin
            width_ff <= csr_data[rgbds_pkg::WIDTH_REG_W-1:0];
         end
         if (csr_index == rgbds_pkg::CSR_IMAGE_HEIGHT) begin
            height_ff <= csr_data[rgbds_pkg::HEIGHT_REG_W-1:0];
         end
      end
   end

   // Effective frame size: zero or oversize width means the maximum width,
   // and zero height means the full 16-bit row range.
   always_comb begin
      if (width_ff == '0 || 32'(width_ff) > 32'(rgbds_pkg::MAX_WIDTH)) begin
         eff_width = rgbds_pkg::EFF_WIDTH_W'(rgbds_pkg::MAX_WIDTH);
      end else begin
         eff_width = rgbds_pkg::EFF_WIDTH_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = {1'b1, {rgbds_pkg::HEIGHT_REG_W{1'b0}}};
      end else begin
         eff_height = {1'b0, height_ff};
      end
   end

   // Counter increments and the last even-aligned column and row.
   assign col_plus    = {1'b0, col_ff} + rgbds_pkg::EFF_WIDTH_W'(1);
   assign row_plus    = {1'b0, row_ff} + rgbds_pkg::EFF_HEIGHT_W'(1);
   assign even_width  = {eff_width[rgbds_pkg::EFF_WIDTH_W-1:1], 1'b0};
   assign even_height = {eff_height[rgbds_pkg::EFF_HEIGHT_W-1:1], 1'b0};

   // Next raster position; a count at or past the limit wraps to zero.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (advance) begin
         if (col_plus >= eff_width) begin
            col_in = '0;
            if (row_plus >= eff_height) begin
               row_in = '0;
            end else begin
               row_in = row_plus[rgbds_pkg::HEIGHT_REG_W-1:0];
            end
         end else begin
            col_in = col_plus[rgbds_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Position flags for the current pixel. An even size of zero never
   // matches, since the incremented counts are at least one.
   assign pos.odd_col   = col_ff[0];
   assign pos.odd_row   = row_ff[0];
   assign pos.last      = (col_plus == even_width) && (row_plus == even_height);
   assign pos.line_addr = col_ff[rgbds_pkg::COL_W-1:1];

endmodule

`default_nettype wire

FILE: rtl/core/rgb_box_downscale_2x2.sv
// Top level of the 2x2 RGB box-filter downscaler: pair sums, line store,
// and the two-stage output pipeline. Depends on rgbds_pkg, rgbds_raster_ctrl.
//
//   Channel   Direction  Handshake                Payload
//   req_*     in         req_valid / req_stall    req_data_type, one pixel
//   rsp_*     out        rsp_valid / rsp_stall    rsp_data_type, one pixel
//   csr_*     in         csr_valid / csr_ready    csr_index, csr_data
//
// One input pixel per clock is accepted while req_stall is low. An output pixel
// is loaded into stage one on the transaction of the bottom-right pixel of its
// block, then passes to the output register and appears on rsp_valid. The line
// store is a 1024 x 27 memory with one write and one registered read per cycle.
// Reset clears the counters and sets a 2 x 2 frame; the line store is not
// cleared, since the even row of each block pair writes it before use.
// req_stall rises only when both pipeline stages are full and rsp_stall is high.
`default_nettype none

module rgb_box_downscale_2x2 (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output      logic                               req_stall,
   input  wire rgbds_pkg::req_data_type            req_data,
   output      logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   output      rgbds_pkg::rsp_data_type            rsp_data,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [rgbds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [rgbds_pkg::CSR_DATA_W-1:0]   csr_data
);

   rgbds_pkg::pos_type      pos;
   rgbds_pkg::req_data_type hold_ff;
   rgbds_pkg::pair_sum_type pair;
   rgbds_pkg::pair_sum_type line_mem [rgbds_pkg::LINE_DEPTH];
   rgbds_pkg::pair_sum_type line_rd_ff;
   rgbds_pkg::pair_sum_type s1_pair_ff;
   rgbds_pkg::rsp_data_type rsp_data_ff, rsp_data_in;
   logic                    s1_last_ff;
   logic                    s1_valid_ff;
   logic                    rsp_valid_ff;
   logic                    s1_ready, s2_ready;
   logic                    accept, emit;
   logic [rgbds_pkg::TOTAL_W-1:0] total_red, total_green, total_blue;

   // Configuration and raster position.
   rgbds_raster_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .advance   (accept),
      .pos       (pos)
   );

   assign csr_ready = 1'b1;

   // Pipeline handshake: each stage loads when it is empty or draining.
   assign s2_ready  = !rsp_valid_ff || !rsp_stall;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;
   assign emit      = pos.odd_col && pos.odd_row;

   // Horizontal pair sum of the held even-column pixel and the current one.
   assign pair.red   = {1'b0, hold_ff.red_in}   + {1'b0, req_data.red_in};
   assign pair.green = {1'b0, hold_ff.green_in} + {1'b0, req_data.green_in};
   assign pair.blue  = {1'b0, hold_ff.blue_in}  + {1'b0, req_data.blue_in};

   // Hold the even-column pixel until its right neighbor arrives.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else if (accept && !pos.odd_col) begin
         hold_ff <= req_data;
      end
   end

   // Line store write: even rows save their pair sums.
   always_ff @(posedge clock) begin
      if (accept && pos.odd_col && !pos.odd_row) begin
         line_mem[pos.line_addr] <= pair;
      end
   end

   // Line store read and stage one payload: odd rows fetch the saved sums.
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         line_rd_ff <= line_mem[pos.line_addr];
         s1_pair_ff <= pair;
         s1_last_ff <= pos.last;
      end
   end

   // Stage one valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept && emit;
      end
   end

   // Vertical sum and truncating divide by four.
   always_comb begin
      total_red   = {1'b0, line_rd_ff.red}   + {1'b0, s1_pair_ff.red};
      total_green = {1'b0, line_rd_ff.green} + {1'b0, s1_pair_ff.green};
      total_blue  = {1'b0, line_rd_ff.blue}  + {1'b0, s1_pair_ff.blue};
      rsp_data_in.red_out   = total_red[rgbds_pkg::TOTAL_W-1:2];
      rsp_data_in.green_out = total_green[rgbds_pkg::TOTAL_W-1:2];
      rsp_data_in.blue_out  = total_blue[rgbds_pkg::TOTAL_W-1:2];
      rsp_data_in.frame_end = s1_last_ff;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rgbds_checker.sv
// Port-level checks for rgb_box_downscale_2x2, attached by the bind below.
// Depends on rgbds_pkg and rgb_box_downscale_2x2.
`default_nettype none

module rgbds_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_stall,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_stall,
   input wire rgbds_pkg::rsp_data_type            rsp_data,
   input wire logic                               csr_valid,
   input wire logic                               csr_ready
);

   // A stalled result transaction stays offered.
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled result payload does not change.
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // With the output register empty the input side is never stalled.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req_stall high with an empty output register");

   // The output register is empty after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // The configuration port never holds off a write.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("csr_ready low during a configuration write");

endmodule

bind rgb_box_downscale_2x2 rgbds_checker u_rgbds_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

`default_nettype wire
